/* rtl/core/wavdf_pkg.sv */
// Shared types for the WAV PCM header deframer: request payloads and status codes.
package wavdf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 32;

    typedef enum logic [2:0] {
        ST_HEADER     = 3'd0,
        ST_PAYLOAD    = 3'd1,
        ST_FINAL      = 3'd2,
        ST_TAG_ERR    = 3'd3,
        ST_FMT_ERR    = 3'd4,
        ST_LAYOUT_ERR = 3'd5,
        ST_TRUNC      = 3'd6,
        ST_IGNORED    = 3'd7
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] content_byte;
        logic              content_last;
    } content_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] data_byte;
        logic              stereo;
        logic              wide_samples;
        logic [WORD_W-1:0] rate_hz;
        logic [WORD_W-1:0] payload_size;
    } result_t;

endpackage

/* rtl/core/wavdf_parser.sv */
// Header parse state machine: takes one byte per step and forms its result.
module wavdf_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  wavdf_pkg::content_t item,
    output wavdf_pkg::result_t  res
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_IGNORE  = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] POS_RIFF  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_WAVE  = POS_W'(11);
    localparam logic [POS_W-1:0] POS_FMT   = POS_W'(15);
    localparam logic [POS_W-1:0] POS_FSIZE = POS_W'(19);
    localparam logic [POS_W-1:0] POS_AFMT  = POS_W'(21);
    localparam logic [POS_W-1:0] POS_CHAN  = POS_W'(23);
    localparam logic [POS_W-1:0] POS_RATE  = POS_W'(27);
    localparam logic [POS_W-1:0] POS_BITS  = POS_W'(35);
    localparam logic [POS_W-1:0] POS_DATA  = POS_W'(39);
    localparam logic [POS_W-1:0] POS_SIZE  = POS_W'(43);

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_SIZE = 32'd16;
    localparam logic [15:0] FMT_PCM  = 16'd1;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [31:0]         fa_reg, fa_next;
    logic [31:0]         remain_reg, remain_next;
    wavdf_pkg::status_t  err_reg, err_next;
    logic [31:0]         rate_reg, rate_next;
    logic [31:0]         size_reg, size_next;
    logic                ch_ok_reg, ch_ok_next;
    logic                stereo_reg, stereo_next;
    logic                bits_ok_reg, bits_ok_next;
    logic                wide_reg, wide_next;

    logic [31:0]         fa;
    logic [15:0]         hi;
    logic                fail;
    wavdf_pkg::status_t  fail_code;
    wavdf_pkg::status_t  status;
    logic [7:0]          data;

    assign fa = {item.content_byte, fa_reg[31:8]};
    assign hi = fa[31:16];

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        fa_next      = fa_reg;
        remain_next  = remain_reg;
        err_next     = err_reg;
        rate_next    = rate_reg;
        size_next    = size_reg;
        ch_ok_next   = ch_ok_reg;
        stereo_next  = stereo_reg;
        bits_ok_next = bits_ok_reg;
        wide_next    = wide_reg;
        fail         = 1'b0;
        fail_code    = wavdf_pkg::ST_TAG_ERR;
        status       = wavdf_pkg::ST_HEADER;
        data         = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                fa_next  = fa;
                pos_next = pos_reg + POS_W'(1);
                case (pos_reg)
                    POS_RIFF:  fail = (fa != TAG_RIFF);
                    POS_WAVE:  fail = (fa != TAG_WAVE);
                    POS_FMT:   fail = (fa != TAG_FMT);
                    POS_FSIZE:
                    begin
                        fail      = (fa != FMT_SIZE);
                        fail_code = wavdf_pkg::ST_FMT_ERR;
                    end
                    POS_AFMT:
                    begin
                        fail      = (hi != FMT_PCM);
                        fail_code = wavdf_pkg::ST_FMT_ERR;
                    end
                    POS_CHAN:
                    begin
                        ch_ok_next  = (hi == 16'd1) || (hi == 16'd2);
                        stereo_next = (hi == 16'd2);
                    end
                    POS_RATE:  rate_next = fa;
                    POS_BITS:
                    begin
                        bits_ok_next = (hi == 16'd8) || (hi == 16'd16);
                        wide_next    = (hi == 16'd16);
                    end
                    POS_DATA:  fail = (fa != TAG_DATA);
                    POS_SIZE:
                    begin
                        size_next = fa;
                        if (!(ch_ok_reg && bits_ok_reg))
                        begin
                            fail      = 1'b1;
                            fail_code = wavdf_pkg::ST_LAYOUT_ERR;
                        end
                        else if (fa == '0)
                        begin
                            phase_next = PH_IGNORE;
                        end
                        else
                        begin
                            phase_next  = PH_PAYLOAD;
                            remain_next = fa;
                        end
                    end
                    default: ;
                endcase
                if (fail)
                begin
                    phase_next = PH_ERROR;
                    err_next   = fail_code;
                    status     = fail_code;
                end
                else if (item.content_last && phase_next != PH_IGNORE)
                begin
                    status = wavdf_pkg::ST_TRUNC;
                end
            end
            PH_PAYLOAD:
            begin
                if (remain_reg <= 32'd1)
                begin
                    status      = wavdf_pkg::ST_FINAL;
                    data        = item.content_byte;
                    remain_next = '0;
                    phase_next  = PH_IGNORE;
                end
                else if (item.content_last)
                begin
                    status = wavdf_pkg::ST_TRUNC;
                end
                else
                begin
                    status      = wavdf_pkg::ST_PAYLOAD;
                    data        = item.content_byte;
                    remain_next = remain_reg - 32'd1;
                end
            end
            PH_IGNORE: status = wavdf_pkg::ST_IGNORED;
            default:   status = err_reg;
        endcase

        res.status       = status;
        res.data_byte    = data;
        res.stereo       = stereo_next;
        res.wide_samples = wide_next;
        res.rate_hz      = rate_next;
        res.payload_size = size_next;

        // end of file: re-arm for the next one
        if (item.content_last)
        begin
            phase_next   = PH_HEADER;
            pos_next     = '0;
            fa_next      = '0;
            remain_next  = '0;
            err_next     = wavdf_pkg::ST_HEADER;
            rate_next    = '0;
            size_next    = '0;
            ch_ok_next   = 1'b0;
            stereo_next  = 1'b0;
            bits_ok_next = 1'b0;
            wide_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            fa_reg      <= '0;
            remain_reg  <= '0;
            err_reg     <= wavdf_pkg::ST_HEADER;
            rate_reg    <= '0;
            size_reg    <= '0;
            ch_ok_reg   <= 1'b0;
            stereo_reg  <= 1'b0;
            bits_ok_reg <= 1'b0;
            wide_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            fa_reg      <= fa_next;
            remain_reg  <= remain_next;
            err_reg     <= err_next;
            rate_reg    <= rate_next;
            size_reg    <= size_next;
            ch_ok_reg   <= ch_ok_next;
            stereo_reg  <= stereo_next;
            bits_ok_reg <= bits_ok_next;
            wide_reg    <= wide_next;
        end
    end

endmodule

/* rtl/core/wav_pcm_header_deframer_core.sv */
// Top level of the WAV PCM header deframer: request pipeline around the parser.
//
//  channel   valid            ready            payload
//  -------   --------------   --------------   -------------------------
//  content   content_valid    content_ready    content (content_t)
//  result    result_valid     result_ready     result  (result_t)
//
// One byte per cycle while result_ready is high; a byte goes through the input
// register, then parser logic into the result register, and a new byte is taken
// into the input register as the previous one moves on to the result register.
// Reset clears the parser state and both valid flags; the next file starts at
// header byte 0. A stalled result holds the input register; content_ready
// drops only when both registers are full and result_ready is low.
module wav_pcm_header_deframer_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                content_valid,
    output logic                content_ready,
    input  wavdf_pkg::content_t content,
    output logic                result_valid,
    input  logic                result_ready,
    output wavdf_pkg::result_t  result
);

    logic                in_valid_reg;
    wavdf_pkg::content_t in_reg;
    logic                out_valid_reg;
    wavdf_pkg::result_t  out_reg;
    wavdf_pkg::result_t  res;
    logic                advance;

    assign advance       = in_valid_reg && (!out_valid_reg || result_ready);
    assign content_ready = !in_valid_reg || advance;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

    wavdf_parser u_parser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (content_ready)
            begin
                in_valid_reg <= content_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (content_ready && content_valid)
        begin
            in_reg <= content;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

`ifndef ASSERT_OFF
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input register lost a pending request");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !content_ready |-> (in_valid_reg && out_valid_reg))
        else $error("content_ready low with a free register");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != wavdf_pkg::ST_PAYLOAD
            && out_reg.status != wavdf_pkg::ST_FINAL) |-> (out_reg.data_byte == '0))
        else $error("data_byte set on a non-payload result");
`endif

endmodule
